// ----- rtl/swp_pkg.sv -----
// swp_pkg: shared types, codes and constant tables for the sliding window engine
// no dependencies; imported by every other file of the block
`default_nettype none

package swp_pkg;

    localparam int unsigned SEQ_W           = 8;
    localparam int unsigned WORD_W          = 32;
    localparam int unsigned SEQ_SPAN        = 256;
    localparam int unsigned SEND_WINDOW_DEF = 8;
    localparam int unsigned RECV_WINDOW_DEF = 8;

    typedef logic [SEQ_W-1:0]  t_seq;
    typedef logic [WORD_W-1:0] t_word;

    // result kinds
    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_DELIVER = 2'd1,
        KIND_ACK     = 2'd2,
        KIND_REFUSE  = 2'd3
    } t_kind;

    // input command code
    localparam logic CMD_SEND = 1'b0;

    typedef struct packed {
        t_kind kind;
        t_seq  seq;
        t_word data;
        logic  last;
    } t_result;

    // sequence number to slot index, one entry per sequence number
    typedef logic [SEQ_SPAN-1:0][SEQ_W-1:0] t_mod_tab;

    function automatic t_mod_tab build_mod_table(input int unsigned rw);
        t_mod_tab    tab;
        int unsigned cnt;
        cnt = 0;
        for (int v = 0; v < SEQ_SPAN; v++) begin
            tab[v] = SEQ_W'(cnt);
            if (cnt + 1 == rw) begin
                cnt = 0;
            end else begin
                cnt = cnt + 1;
            end
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/swp_if.sv -----
// swp_in_if / swp_out_if: valid-ready channels for input items and results
// depends on swp_pkg
`default_nettype none

interface swp_in_if import swp_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  cmd;
    t_word payload;
    t_seq  seq_num;
    t_seq  ack_num;
    logic  ack_valid;
    logic  has_data;

    modport source (output valid, cmd, payload, seq_num, ack_num, ack_valid, has_data,
                    input ready);
    modport sink   (input valid, cmd, payload, seq_num, ack_num, ack_valid, has_data,
                    output ready);
endinterface

interface swp_out_if import swp_pkg::*; ();
    logic  valid;
    logic  ready;
    t_kind kind;
    t_seq  seq_out;
    t_word data_out;
    logic  last;

    modport source (output valid, kind, seq_out, data_out, last, input ready);
    modport sink   (input valid, kind, seq_out, data_out, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/swp_slot_mem.sv -----
// swp_slot_mem: receive slot data store, one write and one registered read port
// depends on swp_pkg
`default_nettype none

module swp_slot_mem import swp_pkg::*; #(
    parameter int unsigned DEPTH = RECV_WINDOW_DEF,
    parameter int unsigned IDX_W = 3
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [IDX_W-1:0] i_wr_addr,
    input  wire t_word            i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [IDX_W-1:0] i_rd_addr,
    output t_word                 o_rd_data
);

    t_word r_mem [DEPTH];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- rtl/swp_out_reg.sv -----
// swp_out_reg: one-entry result register in front of the output channel
// depends on swp_pkg and swp_out_if
`default_nettype none

module swp_out_reg import swp_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_res,
    output logic         o_free,
    swp_out_if.source    o_out
);

    logic    r_valid;
    t_result r_res;

    // free when empty or the held beat leaves this cycle
    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.kind     = r_res.kind;
    assign o_out.seq_out  = r_res.seq;
    assign o_out.data_out = r_res.data;
    assign o_out.last     = r_res.last;

endmodule

`default_nettype wire

// ----- rtl/sliding_window_protocol_engine.sv -----
// Sliding window link engine (selective repeat, both ends), 8-bit wrapping
// sequence numbers. A send request (cmd 0) becomes one data frame beat with the next
// sequence number, or one refusal beat when SEND_WINDOW frames are unacknowledged.
// An arriving frame (cmd 1) may advance the acknowledged number and may store
// its word in the receive slot memory; when it is the expected number the
// engine walks the slots and delivers every consecutive stored word, then one
// cumulative ack beat. The last flag marks the final beat caused by an item.
// A send request passes through ST_SEND to the output register, a frame that
// causes no beat is done when it is taken, and each delivered word costs one
// slot memory read in ST_RD and a pass through ST_DAT for the registered read
// data; the walk ends in ST_RD with the ack. Items are taken one at a time,
// ready is high only while no item is in progress. No clearing pass after reset: the
// received marks are flip-flops cleared at once, the slot data memory has no reset.
// Depends on swp_pkg, swp_if, swp_slot_mem and swp_out_reg.
`default_nettype none

module sliding_window_protocol_engine import swp_pkg::*; #(
    parameter int unsigned SEND_WINDOW = SEND_WINDOW_DEF,
    parameter int unsigned RECV_WINDOW = RECV_WINDOW_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    swp_in_if.sink    i_in,
    swp_out_if.source o_out
);

    localparam int unsigned IDX_W = (RECV_WINDOW > 1) ? $clog2(RECV_WINDOW) : 1;
    localparam int unsigned CNT_W = $clog2(RECV_WINDOW + 1);
    localparam t_mod_tab MOD_TAB  = build_mod_table(RECV_WINDOW);
    // slot of sequence number 1, the first one expected after reset
    localparam logic [IDX_W-1:0] RST_IDX  = MOD_TAB[1][IDX_W-1:0];
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RECV_WINDOW - 1);
    localparam logic [CNT_W-1:0] WALK_MAX = CNT_W'(RECV_WINDOW);
    localparam t_seq SEND_LIM = SEQ_W'(SEND_WINDOW);
    localparam t_seq RECV_LIM = SEQ_W'(RECV_WINDOW);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,  // waiting for an item
        ST_SEND = 4'b0010,  // send result waiting for the output register
        ST_RD   = 4'b0100,  // check the expected slot, read it or finish with the ack
        ST_DAT  = 4'b1000   // slot word in the read register, deliver it
    } t_state;

    t_state               r_state, n_state;
    t_seq                 r_last_sent, n_last_sent;
    t_seq                 r_last_acked, n_last_acked;
    t_seq                 r_next_exp, n_next_exp;
    logic [IDX_W-1:0]     r_exp_idx, n_exp_idx;     // slot of r_next_exp
    logic [CNT_W-1:0]     r_walked, n_walked;       // deliveries in this walk
    logic [RECV_WINDOW-1:0] r_recv, n_recv;         // received marks
    t_result              r_send_res, n_send_res;

    logic             in_acc;
    t_seq             outstanding;
    logic             win_full;
    t_seq             ack_pos, ack_span;
    logic             ack_ok;
    t_seq             rx_pos;
    logic             rx_ok;
    logic [IDX_W-1:0] rx_idx;
    logic             rd_hit;

    logic             mem_wr;
    logic             mem_rd;
    t_word            mem_rd_data;

    logic             out_push;
    logic             out_free;
    t_result          out_res;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;

    // send window: refused once SEND_WINDOW frames are unacknowledged
    assign outstanding = r_last_sent - r_last_acked;
    assign win_full    = (outstanding >= SEND_LIM);

    // ack counts only inside (last_acked, last_sent]
    assign ack_pos  = i_in.ack_num - r_last_acked - 8'd1;
    assign ack_span = r_last_sent - r_last_acked;
    assign ack_ok   = i_in.ack_valid && (ack_pos < ack_span);

    // data counts only inside [next_expected, next_expected + RECV_WINDOW - 1]
    assign rx_pos = i_in.seq_num - r_next_exp;
    assign rx_ok  = i_in.has_data && (rx_pos < RECV_LIM);
    assign rx_idx = MOD_TAB[i_in.seq_num][IDX_W-1:0];

    // walk goes on while the expected slot is marked, at most one window
    assign rd_hit = r_recv[r_exp_idx] && (r_walked < WALK_MAX);

    always_comb begin
        n_state      = r_state;
        n_last_sent  = r_last_sent;
        n_last_acked = r_last_acked;
        n_next_exp   = r_next_exp;
        n_exp_idx    = r_exp_idx;
        n_walked     = r_walked;
        n_recv       = r_recv;
        n_send_res   = r_send_res;
        mem_wr       = 1'b0;
        mem_rd       = 1'b0;
        out_push     = 1'b0;
        out_res      = r_send_res;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.cmd == CMD_SEND) begin
                        if (win_full) begin
                            n_send_res = '{kind: KIND_REFUSE, seq: '0, data: '0, last: 1'b1};
                        end else begin
                            n_last_sent = r_last_sent + 8'd1;
                            n_send_res  = '{kind: KIND_DATA, seq: r_last_sent + 8'd1,
                                            data: i_in.payload, last: 1'b1};
                        end
                        n_state = ST_SEND;
                    end else begin
                        if (ack_ok) begin
                            n_last_acked = i_in.ack_num;
                        end
                        if (rx_ok) begin
                            // store the word, a duplicate overwrites
                            mem_wr         = 1'b1;
                            n_recv[rx_idx] = 1'b1;
                            if (rx_pos == '0) begin
                                n_walked = '0;
                                n_state  = ST_RD;
                            end
                        end
                    end
                end
            end
            ST_SEND: begin
                if (out_free) begin
                    out_push = 1'b1;
                    out_res  = r_send_res;
                    n_state  = ST_IDLE;
                end
            end
            ST_RD: begin
                if (rd_hit) begin
                    // read the slot and clear its mark
                    mem_rd            = 1'b1;
                    n_recv[r_exp_idx] = 1'b0;
                    n_state           = ST_DAT;
                end else if (out_free) begin
                    // cumulative ack closes the walk
                    out_push = 1'b1;
                    out_res  = '{kind: KIND_ACK, seq: r_next_exp - 8'd1, data: '0, last: 1'b1};
                    n_state  = ST_IDLE;
                end
            end
            ST_DAT: begin
                if (out_free) begin
                    out_push   = 1'b1;
                    out_res    = '{kind: KIND_DELIVER, seq: r_next_exp, data: mem_rd_data,
                                   last: 1'b0};
                    n_next_exp = r_next_exp + 8'd1;
                    // slot index follows the sequence number, restarting after the last slot and at the wrap
                    if (r_next_exp == 8'hFF || r_exp_idx == LAST_IDX) begin
                        n_exp_idx = '0;
                    end else begin
                        n_exp_idx = r_exp_idx + IDX_W'(1);
                    end
                    n_walked = r_walked + CNT_W'(1);
                    n_state  = ST_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_last_sent  <= '0;
            r_last_acked <= '0;
            r_next_exp   <= 8'd1;
            r_exp_idx    <= RST_IDX;
            r_walked     <= '0;
            r_recv       <= '0;
        end else begin
            r_state      <= n_state;
            r_last_sent  <= n_last_sent;
            r_last_acked <= n_last_acked;
            r_next_exp   <= n_next_exp;
            r_exp_idx    <= n_exp_idx;
            r_walked     <= n_walked;
            r_recv       <= n_recv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_send_res <= n_send_res;
    end

    swp_slot_mem #(
        .DEPTH (RECV_WINDOW),
        .IDX_W (IDX_W)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr),
        .i_wr_addr (rx_idx),
        .i_wr_data (i_in.payload),
        .i_rd_en   (mem_rd),
        .i_rd_addr (r_exp_idx),
        .o_rd_data (mem_rd_data)
    );

    swp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_res   (out_res),
        .o_free  (out_free),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ----- rtl/swp_checker.sv -----
// swp_checker: port-level assertions for the sliding window engine, bound to the top
// depends on swp_pkg and sliding_window_protocol_engine
`default_nettype none

module swp_checker import swp_pkg::*; (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    input wire logic  i_in_valid,
    input wire logic  i_in_ready,
    input wire logic  i_in_cmd,
    input wire logic  i_out_valid,
    input wire logic  i_out_ready,
    input wire t_kind i_out_kind,
    input wire t_seq  i_out_seq,
    input wire t_word i_out_data,
    input wire logic  i_out_last
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind) &&
        $stable(i_out_seq) && $stable(i_out_data) && $stable(i_out_last))
        else $error("result beat changed while stalled");

    // a send request keeps the input closed for its result cycle
    a_send_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_cmd == CMD_SEND) |=> !i_in_ready)
        else $error("input open right after a send request");

    // only deliveries are followed by more beats of the same item
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_last == (i_out_kind != KIND_DELIVER)))
        else $error("last flag does not match result kind");

    // acks and refusals carry no word
    a_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == KIND_ACK || i_out_kind == KIND_REFUSE)
        |-> i_out_data == '0)
        else $error("ack or refusal carries data");

    // a refusal carries no sequence number
    a_refuse_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == KIND_REFUSE) |-> i_out_seq == '0)
        else $error("refusal carries a sequence number");

endmodule

bind sliding_window_protocol_engine swp_checker u_swp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_cmd    (i_in.cmd),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.kind),
    .i_out_seq   (o_out.seq_out),
    .i_out_data  (o_out.data_out),
    .i_out_last  (o_out.last)
);

`default_nettype wire
